@@ rtl/core/hpc_pkg.sv @@
`default_nettype none

package hpc_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = 16;
    localparam int TDATA_W    = LANES * LANE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FMT_W      = 3;
    localparam int ROW_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd2;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    localparam logic [FMT_W-1:0] FMT_BYTE   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGB8   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGBA8  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGB16  = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGBA16 = 3'd4;

    localparam logic [LANE_W-1:0] BYTE_MASK = 16'h00FF;

    typedef struct packed {
        logic              direction;
        logic [FMT_W-1:0]  pixel_format;
        logic [ROW_W-1:0]  row_length;
    } cfg_t;

    // channel count of a format; undefined codes act as single byte
    function automatic logic [2:0] fmt_channels(input logic [FMT_W-1:0] f);
        logic [2:0] n;
        case (f)
            FMT_RGB8:   n = 3'd3;
            FMT_RGBA8:  n = 3'd4;
            FMT_RGB16:  n = 3'd3;
            FMT_RGBA16: n = 3'd4;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic fmt_wide(input logic [FMT_W-1:0] f);
        return (f == FMT_RGB16) || (f == FMT_RGBA16);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/horizontal_predictor_codec_core.sv @@
// Horizontal differencing predictor, one pixel of up to four channels per item.
// Input stream s_*: tdata carries the four channel samples; unused channels are
// ignored. Result stream m_*: tdata carries the predicted channels (unused ones
// zero), tlast marks the last item of a row.
// Decode adds the previous decoded pixel, encode subtracts the previous original
// pixel; the first pixel of a row passes through. Byte formats wrap at 8 bits,
// 16-bit formats at the channel width.
// Configuration: cfg_wr_en with cfg_index 0 direction, 1 pixel format,
// 2 row length; write only while no item is in flight. Writes keep row state.
// From input accept to result valid an item passes the input stage register,
// then the result register. Throughput: one item per cycle while m_tready is
// high, set by the single add/subtract per channel between those two registers.
// Reset (aresetn low, synchronous) clears the stream valids, the previous pixel,
// the column counter and the registers to decode, single byte, row length 1.
// When m_tready is low the result holds; the input stage and a one-item skid
// absorb what is in flight, and s_tready drops only once the skid is full.
`default_nettype none

module horizontal_predictor_codec_core #(
    parameter int CHANNEL_WIDTH = 16,
    parameter int CHANNELS      = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [hpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // chan_a [15:0], chan_b [31:16], chan_c [47:32], chan_d [63:48]
    input  wire logic [hpc_pkg::TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // out_a [15:0], out_b [31:16], out_c [47:32], out_d [63:48]
    output logic [hpc_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                m_tlast
);

    hpc_pkg::cfg_t               cfg_reg;
    logic                        stage_valid;
    logic                        stage_ready;
    logic [hpc_pkg::TDATA_W-1:0] stage_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.direction    <= hpc_pkg::DIR_DECODE;
            cfg_reg.pixel_format <= hpc_pkg::FMT_BYTE;
            cfg_reg.row_length   <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hpc_pkg::CFG_DIRECTION:  cfg_reg.direction    <= cfg_wdata[0];
                hpc_pkg::CFG_FORMAT:     cfg_reg.pixel_format <= cfg_wdata[hpc_pkg::FMT_W-1:0];
                hpc_pkg::CFG_ROW_LENGTH: cfg_reg.row_length   <= cfg_wdata[hpc_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    hpc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (stage_valid),
        .out_ready (stage_ready),
        .out_data  (stage_data)
    );

    hpc_datapath #(
        .CHANNEL_WIDTH (CHANNEL_WIDTH),
        .CHANNELS      (CHANNELS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (stage_valid),
        .in_ready (stage_ready),
        .in_data  (stage_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // input side backs up only after the result side stalled
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("s_tready low without a prior output stall");

    // a new result comes only from an item held in the input stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(stage_valid))
        else $error("result appeared without an input stage item");

    // input stage never drains while the result register is stalled
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid && m_tvalid && !m_tready) |=> stage_valid)
        else $error("input stage item lost during stall");

endmodule

`default_nettype wire

@@ rtl/core/hpc_skid.sv @@
`default_nettype none

module hpc_skid (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [hpc_pkg::TDATA_W-1:0] in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [hpc_pkg::TDATA_W-1:0]      out_data
);

    logic                        main_valid_reg;
    logic [hpc_pkg::TDATA_W-1:0] main_data_reg;
    logic                        skid_valid_reg;
    logic [hpc_pkg::TDATA_W-1:0] skid_data_reg;
    logic                        consume;
    logic                        take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign consume   = main_valid_reg && out_ready;
    assign take      = in_valid && !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (consume) begin
                main_data_reg  <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (take) begin
            if (!main_valid_reg || consume) begin
                main_data_reg  <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                // stage busy and stalled: park the item
                skid_data_reg  <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (consume) begin
            main_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/hpc_datapath.sv @@
`default_nettype none

module hpc_datapath #(
    parameter int CHANNEL_WIDTH = 16,
    parameter int CHANNELS      = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire hpc_pkg::cfg_t               cfg,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [hpc_pkg::TDATA_W-1:0] in_data,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [hpc_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tlast
);

    localparam logic [hpc_pkg::LANE_W-1:0] WIDE_MASK =
        hpc_pkg::LANE_W'((32'd1 << CHANNEL_WIDTH) - 32'd1);

    logic                              load;
    logic [2:0]                        nch;
    logic [hpc_pkg::LANE_W-1:0]        lane_mask;
    logic                              first;
    logic                              last;
    logic [hpc_pkg::ROW_W:0]           len_ext;
    logic [hpc_pkg::ROW_W:0]           col_inc;
    logic [hpc_pkg::ROW_W-1:0]         col_reg;
    logic [hpc_pkg::ROW_W-1:0]         col_next;
    logic [hpc_pkg::LANE_W-1:0]        res [hpc_pkg::LANES];
    logic [CHANNEL_WIDTH-1:0]          prev_reg [CHANNELS];
    logic                              out_valid_reg;
    logic [hpc_pkg::TDATA_W-1:0]       out_data_reg;
    logic                              out_last_reg;

    assign in_ready  = !out_valid_reg || m_tready;
    assign load      = in_valid && in_ready;
    assign nch       = hpc_pkg::fmt_channels(cfg.pixel_format);
    assign lane_mask = hpc_pkg::fmt_wide(cfg.pixel_format) ? WIDE_MASK : hpc_pkg::BYTE_MASK;

    // zero row length acts as one
    assign len_ext  = (cfg.row_length == '0) ? 17'd1 : {1'b0, cfg.row_length};
    assign col_inc  = {1'b0, col_reg} + 17'd1;
    assign first    = (col_reg == '0);
    assign last     = (col_inc >= len_ext);
    assign col_next = last ? '0 : col_inc[hpc_pkg::ROW_W-1:0];

    for (genvar k = 0; k < hpc_pkg::LANES; k++) begin : g_lane
        if (k < CHANNELS) begin : g_used
            logic                       active;
            logic [hpc_pkg::LANE_W-1:0] x;
            logic [hpc_pkg::LANE_W-1:0] prev_ext;
            logic [hpc_pkg::LANE_W-1:0] y;
            logic [CHANNEL_WIDTH-1:0]   prev_next;

            assign active   = (3'(k) < nch);
            assign x        = in_data[k*hpc_pkg::LANE_W +: hpc_pkg::LANE_W] & lane_mask;
            assign prev_ext = hpc_pkg::LANE_W'(prev_reg[k]);

            always_comb begin
                if (first) begin
                    y = x;
                end else if (cfg.direction == hpc_pkg::DIR_DECODE) begin
                    y = (x + prev_ext) & lane_mask;
                end else begin
                    y = (x - prev_ext) & lane_mask;
                end
            end

            // decode keeps the reconstructed pixel, encode the original
            assign prev_next = CHANNEL_WIDTH'((cfg.direction == hpc_pkg::DIR_DECODE) ? y : x);
            assign res[k]    = active ? y : '0;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    prev_reg[k] <= '0;
                end else if (load && active) begin
                    prev_reg[k] <= prev_next;
                end
            end
        end else begin : g_unused
            assign res[k] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                col_reg       <= col_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= {res[3], res[2], res[1], res[0]};
                out_last_reg  <= last;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
